FILE: rtl/core/lmtrr_pkg.sv
// Shared types and constants for the LED matrix text row renderer.
// Used by the front, the command queue, the render back end and the top level.
package lmtrr_pkg;

  localparam int FONT_BYTES_DEF = 1024;
  localparam int TEXT_CHARS_DEF = 64;
  localparam int MAX_ROW_LEDS   = 64;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [23:0] COLOUR_ON  = 24'h3F0000;
  localparam logic [23:0] COLOUR_OFF = 24'h000000;
  localparam logic [7:0]  SPACE_CODE = 8'h20;
  localparam logic [2:0]  MSB_COL    = 3'd7;

  // Input item kinds
  localparam logic [1:0] KIND_FONT_WR = 2'd0;
  localparam logic [1:0] KIND_TEXT_WR = 2'd1;
  localparam logic [1:0] KIND_RENDER  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_MATRIX_ROWS     = 3'd0;
  localparam logic [2:0] REG_LEDS_IN_ROW     = 3'd1;
  localparam logic [2:0] REG_ZIGZAG_MODE     = 3'd2;
  localparam logic [2:0] REG_GLYPH_WIDTH     = 3'd3;
  localparam logic [2:0] REG_GLYPH_HEIGHT    = 3'd4;
  localparam logic [2:0] REG_FIRST_FONT_CHAR = 3'd5;

  typedef enum logic [1:0] {
    CMD_FONT_WR,
    CMD_TEXT_WR,
    CMD_RENDER
  } cmd_t;

  typedef struct packed {
    logic [4:0] matrix_rows;
    logic [6:0] leds_in_row;
    logic       zigzag_mode;
    logic [3:0] glyph_width;
    logic [4:0] glyph_height;
    logic [7:0] first_font_char;
  } cfg_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [9:0] addr;
    logic [7:0] data;
    logic [3:0] row;
    logic [5:0] first;
    logic [2:0] offset;
    logic [6:0] tlen;
  } cmd_item_t;

endpackage

FILE: rtl/core/led_matrix_text_row_renderer_top.sv
// Top level of the LED matrix text row renderer: configuration registers,
// front end, command queue and render back end. Depends on lmtrr_pkg.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  input   | in_valid / in_ready  | kind, store_address, store_data, row_index,
//          |                      | start_letter, inner_offset, text_length
//  output  | out_valid/out_ready  | pixel_index, pixel_on, pixel_colour,
//          |                      | last_pixel
//  config  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A render walks its row through the four-stage pixel pipeline, while a store
// write or a zero-length row retires as soon as it leaves the queue. The next
// command starts once the pixel pipeline has drained. Up to four commands
// wait in the queue, so the input side keeps accepting for a while when the
// output stalls; an output stall freezes the whole pipeline.
// Synchronous reset clears control state and loads config defaults; the font
// and text memories are not cleared.
module led_matrix_text_row_renderer_top #(
  parameter int FONT_BYTES = lmtrr_pkg::FONT_BYTES_DEF,
  parameter int TEXT_CHARS = lmtrr_pkg::TEXT_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [9:0]  store_address,
  input  logic [7:0]  store_data,
  input  logic [3:0]  row_index,
  input  logic [5:0]  start_letter,
  input  logic [2:0]  inner_offset,
  input  logic [6:0]  text_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  pixel_index,
  output logic        pixel_on,
  output logic [23:0] pixel_colour,
  output logic        last_pixel
);
  import lmtrr_pkg::*;

  cfg_t      cfg;
  cmd_item_t push_item;
  cmd_item_t q_item;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.matrix_rows     <= 5'd8;
      cfg.leds_in_row     <= 7'd32;
      cfg.zigzag_mode     <= 1'b0;
      cfg.glyph_width     <= 4'd8;
      cfg.glyph_height    <= 5'd8;
      cfg.first_font_char <= 8'd32;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MATRIX_ROWS:     cfg.matrix_rows     <= cfg_data[4:0];
        REG_LEDS_IN_ROW:     cfg.leds_in_row     <= cfg_data[6:0];
        REG_ZIGZAG_MODE:     cfg.zigzag_mode     <= cfg_data[0];
        REG_GLYPH_WIDTH:     cfg.glyph_width     <= cfg_data[3:0];
        REG_GLYPH_HEIGHT:    cfg.glyph_height    <= cfg_data[4:0];
        REG_FIRST_FONT_CHAR: cfg.first_font_char <= cfg_data;
        default: ;
      endcase
    end
  end

  lmtrr_front #(
    .FONT_BYTES(FONT_BYTES),
    .TEXT_CHARS(TEXT_CHARS)
  ) u_front (
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .store_address (store_address),
    .store_data    (store_data),
    .row_index     (row_index),
    .start_letter  (start_letter),
    .inner_offset  (inner_offset),
    .text_length   (text_length),
    .queue_full    (q_full),
    .push          (q_push),
    .item          (push_item)
  );

  lmtrr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (push_item),
    .pop      (q_pop),
    .item_out (q_item),
    .full     (q_full),
    .empty    (q_empty)
  );

  lmtrr_back #(
    .FONT_BYTES(FONT_BYTES),
    .TEXT_CHARS(TEXT_CHARS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_item       (q_item),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_index  (pixel_index),
    .pixel_on     (pixel_on),
    .pixel_colour (pixel_colour),
    .last_pixel   (last_pixel)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command popped from an empty queue");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("pixel presented right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_index) &&
      $stable(pixel_on) && $stable(pixel_colour) && $stable(last_pixel))
    else $error("pixel dropped or changed while stalled");

endmodule

FILE: rtl/core/lmtrr_front.sv
// Front end: accepts input items, drops the ones with no effect and turns
// the rest into queue commands. Depends on lmtrr_pkg.
module lmtrr_front #(
  parameter int FONT_BYTES = lmtrr_pkg::FONT_BYTES_DEF,
  parameter int TEXT_CHARS = lmtrr_pkg::TEXT_CHARS_DEF
) (
  input  lmtrr_pkg::cfg_t      cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           kind,
  input  logic [9:0]           store_address,
  input  logic [7:0]           store_data,
  input  logic [3:0]           row_index,
  input  logic [5:0]           start_letter,
  input  logic [2:0]           inner_offset,
  input  logic [6:0]           text_length,
  input  logic                 queue_full,
  output logic                 push,
  output lmtrr_pkg::cmd_item_t item
);
  import lmtrr_pkg::*;

  logic keep;

  always_comb begin
    item.cmd    = CMD_RENDER;
    item.addr   = store_address;
    item.data   = store_data;
    item.row    = row_index;
    item.first  = start_letter;
    item.offset = inner_offset;
    item.tlen   = text_length;
    keep        = 1'b0;
    unique case (kind)
      KIND_FONT_WR: begin
        item.cmd = CMD_FONT_WR;
        keep     = {3'b000, store_address} < 13'(FONT_BYTES);
      end
      KIND_TEXT_WR: begin
        item.cmd = CMD_TEXT_WR;
        keep     = {1'b0, store_address} < 11'(TEXT_CHARS);
      end
      KIND_RENDER: begin
        // rows outside the matrix or the glyph emit nothing and do not flip
        keep = ({1'b0, row_index} < cfg.matrix_rows) &&
               ({1'b0, row_index} < cfg.glyph_height);
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready && keep;

endmodule

FILE: rtl/core/lmtrr_queue.sv
// Short command queue between the front end and the render back end.
// Depends on lmtrr_pkg for the command item type.
module lmtrr_queue #(
  parameter int DEPTH = lmtrr_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lmtrr_pkg::cmd_item_t item_in,
  input  logic                 pop,
  output lmtrr_pkg::cmd_item_t item_out,
  output logic                 full,
  output logic                 empty
);
  import lmtrr_pkg::*;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = AW + 1;

  cmd_item_t          entries [DEPTH];
  logic [AW-1:0]      wr_ptr;
  logic [AW-1:0]      rd_ptr;
  logic [CNT_W-1:0]   fill;

  assign full     = (fill == CNT_W'(DEPTH));
  assign empty    = (fill == '0);
  assign item_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

endmodule

FILE: rtl/core/lmtrr_back.sv
// Render back end: owns the font and text memories, runs store writes and
// walks a row one pixel per cycle, unless the output stalls, through a
// four-stage pipeline. Depends on lmtrr_pkg.
module lmtrr_back #(
  parameter int FONT_BYTES = lmtrr_pkg::FONT_BYTES_DEF,
  parameter int TEXT_CHARS = lmtrr_pkg::TEXT_CHARS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lmtrr_pkg::cfg_t      cfg,
  input  lmtrr_pkg::cmd_item_t q_item,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [9:0]           pixel_index,
  output logic                 pixel_on,
  output logic [23:0]          pixel_colour,
  output logic                 last_pixel
);
  import lmtrr_pkg::*;

  localparam int FONT_AW = $clog2(FONT_BYTES);
  localparam int TEXT_AW = (TEXT_CHARS > 1) ? $clog2(TEXT_CHARS) : 1;

  logic [7:0] font_mem [FONT_BYTES];
  logic [7:0] text_mem [TEXT_CHARS];

  // render context, captured whenever a command is taken from the queue
  logic [3:0]  row;
  logic [6:0]  count;
  logic        row_left;
  logic [6:0]  tlen;
  logic [5:0]  first;
  logic        leftward;

  // pixel generator
  logic        gen_active;
  logic [6:0]  col;
  logic [6:0]  letter;
  logic [3:0]  bit_col;

  // pipeline stages
  logic        v1, v2, v3;
  logic [7:0]  text1;
  logic        space1;
  logic [3:0]  bit1, bit2, bit3;
  logic        last1, last2, last3;
  logic [9:0]  pidx1, pidx2, pidx3;
  logic [12:0] faddr2;
  logic        blank2, blank3;
  logic [7:0]  fdata3;

  logic        adv;
  logic        pipe_empty;
  logic [6:0]  row_count;
  logic [6:0]  col_inc;
  logic [4:0]  bit_inc;
  logic        bit_wrap;
  logic [7:0]  pos;
  logic [6:0]  offs;
  logic [10:0] row_base;
  logic [10:0] pidx_sum;
  logic [7:0]  code;
  logic [7:0]  glyph_idx;
  logic [12:0] glyph_base;
  logic        pix;

  assign adv        = !out_valid || out_ready;
  assign pipe_empty = !gen_active && !v1 && !v2 && !v3;
  // take the next command only once the previous render has drained
  assign q_pop      = !q_empty && pipe_empty;

  assign row_count = (cfg.leds_in_row < 7'(MAX_ROW_LEDS)) ? cfg.leds_in_row
                                                           : 7'(MAX_ROW_LEDS);
  assign col_inc   = col + 7'd1;
  assign bit_inc   = {1'b0, bit_col} + 5'd1;
  assign bit_wrap  = bit_inc >= {1'b0, cfg.glyph_width};

  assign pos       = {2'b00, first} + {1'b0, letter};
  assign offs      = row_left ? (count - 7'd1 - col) : col;
  assign row_base  = {7'b0, row} * {4'b0, count};
  assign pidx_sum  = row_base + {4'b0, offs};

  assign code       = space1 ? SPACE_CODE : text1;
  assign glyph_idx  = code - cfg.first_font_char;
  assign glyph_base = {5'b0, glyph_idx} * {8'b0, cfg.glyph_height};

  assign pix = !blank3 && fdata3[MSB_COL - bit3[2:0]];

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_active <= 1'b0;
      leftward   <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (q_pop && q_item.cmd == CMD_RENDER) begin
        gen_active <= (row_count != 7'd0);
        if (cfg.zigzag_mode) begin
          leftward <= !leftward;
        end
      end else if (gen_active && adv && col_inc == count) begin
        gen_active <= 1'b0;
      end
      if (adv) begin
        v1        <= gen_active;
        v2        <= v1;
        v3        <= v2;
        out_valid <= v3;
      end
    end
  end

  // render context and generator counters
  always_ff @(posedge clk) begin
    if (q_pop) begin
      row      <= q_item.row;
      count    <= row_count;
      row_left <= leftward;
      tlen     <= q_item.tlen;
      first    <= q_item.first;
      col      <= '0;
      letter   <= '0;
      bit_col  <= {1'b0, q_item.offset};
    end else if (gen_active && adv) begin
      col <= col_inc;
      if (bit_wrap) begin
        bit_col <= '0;
        letter  <= letter + 7'd1;
      end else begin
        bit_col <= bit_inc[3:0];
      end
    end
  end

  // store writes
  always_ff @(posedge clk) begin
    if (q_pop && q_item.cmd == CMD_FONT_WR) begin
      font_mem[FONT_AW'(q_item.addr)] <= q_item.data;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.cmd == CMD_TEXT_WR) begin
      text_mem[TEXT_AW'(q_item.addr)] <= q_item.data;
    end
  end

  // stage 1: text read, strip index
  always_ff @(posedge clk) begin
    if (adv) begin
      text1  <= text_mem[pos[TEXT_AW-1:0]];
      space1 <= (pos >= {1'b0, tlen}) || ({1'b0, pos} >= 9'(TEXT_CHARS));
      bit1   <= bit_col;
      last1  <= (col_inc == count);
      pidx1  <= pidx_sum[9:0];
    end
  end

  // stage 2: glyph byte address
  always_ff @(posedge clk) begin
    if (adv) begin
      faddr2 <= glyph_base + {9'b0, row};
      blank2 <= (code < cfg.first_font_char) || bit1[3];
      bit2   <= bit1;
      last2  <= last1;
      pidx2  <= pidx1;
    end
  end

  // stage 3: font read
  always_ff @(posedge clk) begin
    if (adv) begin
      fdata3 <= font_mem[FONT_AW'(faddr2)];
      blank3 <= blank2 || (faddr2 >= 13'(FONT_BYTES));
      bit3   <= bit2;
      last3  <= last2;
      pidx3  <= pidx2;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_index  <= pidx3;
      pixel_on     <= pix;
      pixel_colour <= pix ? COLOUR_ON : COLOUR_OFF;
      last_pixel   <= last3;
    end
  end

endmodule

FILE: test/tb_led_matrix_text_row_renderer_top.sv
// Testbench for led_matrix_text_row_renderer_top: font/text store writes, row renders, config.
// Keeps its own model of the stores, config and row direction and checks every pixel transfer.
// Depends on lmtrr_pkg and the top level RTL only.
module tb_led_matrix_text_row_renderer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lmtrr_pkg::*;

  localparam logic [1:0]  KIND_UNUSED  = 2'd3;
  localparam int          IDLE_CYCLES  = 80;
  localparam int          LONG_HOLD    = 400;
  localparam int          MAX_REPORTS  = 10;
  // total input items over the run, store loads included
  localparam int          ITEM_TARGET  = 370;
  localparam int          RANDOM_PHASES = 6;
  localparam longint      TIMEOUT_NS   = 64'd6_000_000;

  typedef struct {
    logic [1:0] kind;
    logic [9:0] addr;
    logic [7:0] data;
    logic [3:0] row;
    logic [5:0] first;
    logic [2:0] offset;
    logic [6:0] tlen;
  } led_req_t;

  typedef struct {
    logic [9:0]  index;
    logic        on;
    logic [23:0] colour;
    logic        last;
  } pixel_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SKIP_FOURTH, RX_SPARSE} rx_mode_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = '0;
  logic [9:0]  store_address = '0;
  logic [7:0]  store_data = '0;
  logic [3:0]  row_index = '0;
  logic [5:0]  start_letter = '0;
  logic [2:0]  inner_offset = '0;
  logic [6:0]  text_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  pixel_index;
  logic        pixel_on;
  logic [23:0] pixel_colour;
  logic        last_pixel;

  // shadow state of the block
  logic [7:0] font_mem [FONT_BYTES_DEF];
  logic [7:0] text_mem [TEXT_CHARS_DEF];
  bit         font_seen [FONT_BYTES_DEF];
  bit         text_seen [TEXT_CHARS_DEF];
  logic       leftward = 1'b0;
  cfg_t       shadow_cfg;

  pixel_t      pending_pixels [$];
  int unsigned failures = 0;
  int unsigned burst_left = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  int unsigned items_sent = 0;

  led_matrix_text_row_renderer_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .store_address(store_address),
    .store_data(store_data), .row_index(row_index), .start_letter(start_letter),
    .inner_offset(inner_offset), .text_length(text_length),
    .out_valid(out_valid), .out_ready(out_ready), .pixel_index(pixel_index),
    .pixel_on(pixel_on), .pixel_colour(pixel_colour), .last_pixel(last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  task automatic flag(input string what);
    failures++;
    if (failures <= MAX_REPORTS) $display("%s", what);
  endtask

  // ---------------------------------------------------------------- model

  function automatic bit row_drawable(input logic [3:0] row);
    return row < shadow_cfg.matrix_rows && row < shadow_cfg.glyph_height;
  endfunction

  function automatic int unsigned row_count();
    return shadow_cfg.leds_in_row < MAX_ROW_LEDS ? shadow_cfg.leds_in_row : MAX_ROW_LEDS;
  endfunction

  function automatic bit text_live(input int unsigned pos, input logic [6:0] tlen);
    return pos < tlen && pos < TEXT_CHARS_DEF;
  endfunction

  // past the end of the text a space is shown
  function automatic logic [7:0] shown_code(input int unsigned pos, input logic [6:0] tlen);
    return text_live(pos, tlen) ? text_mem[pos] : SPACE_CODE;
  endfunction

  // false when the pixel is blank without touching the font store
  function automatic bit glyph_addr(input logic [7:0] code, input logic [3:0] row,
                                    input int unsigned col, output int unsigned addr);
    addr = 0;
    if (code < shadow_cfg.first_font_char || col > MSB_COL) return 1'b0;
    addr = int'(code - shadow_cfg.first_font_char) * int'(shadow_cfg.glyph_height) + int'(row);
    return addr < FONT_BYTES_DEF;
  endfunction

  function automatic void next_column(inout int unsigned letter, inout int unsigned col);
    col++;
    if (col >= shadow_cfg.glyph_width) begin
      col = 0;
      letter++;
    end
  endfunction

  task automatic absorb_request(input led_req_t r);
    int unsigned count, letter, col, addr, offs;
    logic [7:0] code;
    pixel_t px;
    case (r.kind)
      KIND_FONT_WR: begin
        font_mem[r.addr] = r.data;
        font_seen[r.addr] = 1'b1;
      end
      KIND_TEXT_WR: begin
        if (r.addr < TEXT_CHARS_DEF) begin
          text_mem[r.addr] = r.data;
          text_seen[r.addr] = 1'b1;
        end
      end
      KIND_RENDER: begin
        if (row_drawable(r.row)) begin
          count = row_count();
          letter = 0;
          col = r.offset;
          for (int i = 0; i < count; i++) begin
            code = shown_code(r.first + letter, r.tlen);
            px.on = glyph_addr(code, r.row, col, addr) && font_mem[addr][7 - col];
            offs = leftward ? count - 1 - i : i;
            px.index = 10'(int'(r.row) * count + offs);
            px.colour = px.on ? COLOUR_ON : COLOUR_OFF;
            px.last = (i + 1 == count);
            pending_pixels.push_back(px);
            next_column(letter, col);
          end
          if (shadow_cfg.zigzag_mode) leftward = ~leftward;
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- pixel checker

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        flag($sformatf("pixel with nothing pending: idx=%0d on=%0b colour=%06h last=%0b",
                       pixel_index, pixel_on, pixel_colour, last_pixel));
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_index !== want.index || pixel_on !== want.on ||
            pixel_colour !== want.colour || last_pixel !== want.last) begin
          flag($sformatf("pixel mismatch: want idx=%0d on=%0b colour=%06h last=%0b, got idx=%0d on=%0b colour=%06h last=%0b",
                         want.index, want.on, want.colour, want.last,
                         pixel_index, pixel_on, pixel_colour, last_pixel));
        end
      end
    end
  end

  // ---------------------------------------------------------------- pixel sink

  initial begin : pixel_sink
    rx_mode_t mode;
    int unsigned mode_left, beat, hold_left;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_served != holds_asked) begin
        hold_left = LONG_HOLD;
        holds_served++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        beat++;
        case (mode)
          RX_OPEN:        out_ready <= 1'b1;
          RX_COIN:        out_ready <= 1'($urandom_range(0, 1));
          RX_SKIP_FOURTH: out_ready <= (beat % 4) != 0;
          default:        out_ready <= (beat % 5) < 2;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_item(input led_req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(0, 7) == 0 ? $urandom_range(30, 80) : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    kind          <= r.kind;
    store_address <= r.addr;
    store_data    <= r.data;
    row_index     <= r.row;
    start_letter  <= r.first;
    inner_offset  <= r.offset;
    text_length   <= r.tlen;
    do @(posedge clk); while (!in_ready);
    absorb_request(r);
    items_sent++;
    burst_left--;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(REG_MATRIX_ROWS, 8'(c.matrix_rows));
    write_reg(REG_LEDS_IN_ROW, 8'(c.leds_in_row));
    write_reg(REG_ZIGZAG_MODE, 8'(c.zigzag_mode));
    write_reg(REG_GLYPH_WIDTH, 8'(c.glyph_width));
    write_reg(REG_GLYPH_HEIGHT, 8'(c.glyph_height));
    write_reg(REG_FIRST_FONT_CHAR, c.first_font_char);
    cfg_valid <= 1'b0;
    shadow_cfg = c;
  endtask

  // drain all pixels, then give queued no-output commands time to retire
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- item builders

  function automatic led_req_t store_write(input logic [1:0] k, input int unsigned addr,
                                           input logic [7:0] data);
    led_req_t r;
    r.kind = k;
    r.addr = 10'(addr);
    r.data = data;
    r.row = 4'($urandom_range(0, 15));
    r.first = 6'($urandom_range(0, 63));
    r.offset = 3'($urandom_range(0, 7));
    r.tlen = 7'($urandom_range(0, TEXT_CHARS_DEF));
    return r;
  endfunction

  function automatic led_req_t render_req(input int unsigned row, input int unsigned first,
                                          input int unsigned offset, input int unsigned tlen);
    led_req_t r;
    r = store_write(KIND_RENDER, $urandom_range(0, 1023), 8'($urandom_range(0, 255)));
    r.row = 4'(row);
    r.first = 6'(first);
    r.offset = 3'(offset);
    r.tlen = 7'(tlen);
    return r;
  endfunction

  // mostly codes that land inside the font, some spaces and some anything
  function automatic logic [7:0] rand_code();
    int unsigned span;
    span = shadow_cfg.glyph_height == 0 ? 0 : FONT_BYTES_DEF / shadow_cfg.glyph_height - 1;
    if (span > 255 - shadow_cfg.first_font_char) span = 255 - shadow_cfg.first_font_char;
    case ($urandom_range(0, 9))
      0:       return SPACE_CODE;
      1:       return 8'($urandom_range(0, 255));
      default: return 8'(shadow_cfg.first_font_char + $urandom_range(0, span));
    endcase
  endfunction

  function automatic led_req_t rand_render();
    int unsigned reach, row, tl, first, offset;
    reach = shadow_cfg.matrix_rows < shadow_cfg.glyph_height ?
            shadow_cfg.matrix_rows : shadow_cfg.glyph_height;
    if (reach > 16) reach = 16;
    row = ($urandom_range(0, 9) == 0 || reach == 0) ? $urandom_range(0, 15)
                                                    : $urandom_range(0, reach - 1);
    tl = $urandom_range(0, TEXT_CHARS_DEF);
    first = ($urandom_range(0, 9) < 7 && tl != 0) ? $urandom_range(0, tl - 1)
                                                  : $urandom_range(0, 63);
    offset = ($urandom_range(0, 9) < 7 && shadow_cfg.glyph_width inside {[1:8]}) ?
             $urandom_range(0, shadow_cfg.glyph_width - 1) : $urandom_range(0, 7);
    return render_req(row, first, offset, tl);
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.matrix_rows = 5'($urandom_range(0, 7) == 0 ? $urandom_range(17, 31) : $urandom_range(1, 16));
    case ($urandom_range(0, 9))
      0:       c.leds_in_row = 7'($urandom_range(65, 127));
      1:       c.leds_in_row = 7'd0;
      default: c.leds_in_row = 7'($urandom_range(1, 64));
    endcase
    c.zigzag_mode = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       c.glyph_width = 4'd0;
      1:       c.glyph_width = 4'($urandom_range(9, 15));
      default: c.glyph_width = 4'($urandom_range(1, 8));
    endcase
    c.glyph_height = 5'($urandom_range(1, 16));
    c.first_font_char = 8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : 32);
    return c;
  endfunction

  // write every store entry the render will read that has not been written yet
  task automatic load_render_sources(input led_req_t r);
    int unsigned letter, col, pos, addr;
    if (!row_drawable(r.row)) return;
    letter = 0;
    col = r.offset;
    for (int i = 0; i < row_count(); i++) begin
      pos = r.first + letter;
      if (text_live(pos, r.tlen) && !text_seen[pos])
        send_item(store_write(KIND_TEXT_WR, pos, rand_code()));
      if (glyph_addr(shown_code(pos, r.tlen), r.row, col, addr) && !font_seen[addr])
        send_item(store_write(KIND_FONT_WR, addr, 8'($urandom_range(0, 255))));
      next_column(letter, col);
    end
  endtask

  task automatic send_render(input led_req_t r);
    load_render_sources(r);
    send_item(r);
  endtask

  // ---------------------------------------------------------------- tests

  // default config: store extremes, ignored writes, unused kind, blank text
  task automatic test_store_and_blank_cases();
    led_req_t r;
    send_item(store_write(KIND_FONT_WR, 1023, 8'hFF));
    send_item(store_write(KIND_FONT_WR, 0, 8'h00));
    send_item(store_write(KIND_TEXT_WR, 63, 8'h7F));
    send_item(store_write(KIND_TEXT_WR, 1023, 8'hFF));
    r = store_write(KIND_UNUSED, 1023, 8'hFF);
    r.row = 4'hF;
    r.first = 6'h3F;
    r.offset = 3'h7;
    r.tlen = 7'd64;
    send_item(r);
    send_render(render_req(15, 0, 0, 0));
    send_render(render_req(0, 0, 0, 0));
    send_render(render_req(7, 63, 7, 64));
    send_render(render_req(3, 10, 3, 20));
    send_render(render_req(5, 0, 0, 64));
    wait_idle();
  endtask

  task automatic test_config_extremes();
    apply_config('{matrix_rows: 5'd1, leds_in_row: 7'd1, zigzag_mode: 1'b0,
                   glyph_width: 4'd1, glyph_height: 5'd1, first_font_char: 8'd0});
    send_render(render_req(0, 0, 0, 64));
    send_render(render_req(1, 0, 0, 64));
    send_render(render_req(0, 5, 7, 6));
    wait_idle();
    apply_config('{matrix_rows: 5'd16, leds_in_row: 7'd64, zigzag_mode: 1'b1,
                   glyph_width: 4'd8, glyph_height: 5'd16, first_font_char: 8'd255});
    send_render(render_req(0, 0, 0, 64));
    send_render(render_req(15, 63, 7, 64));
    send_render(render_req(8, 2, 4, 10));
    wait_idle();
    // out-of-range widths: zero glyph width and rows beyond the 4-bit row index
    apply_config('{matrix_rows: 5'd31, leds_in_row: 7'd127, zigzag_mode: 1'b1,
                   glyph_width: 4'd0, glyph_height: 5'd31, first_font_char: 8'd0});
    send_render(render_req(15, 0, 3, 64));
    send_render(render_req(2, 30, 0, 50));
    wait_idle();
    // zero LEDs per row still flips the direction
    apply_config('{matrix_rows: 5'd8, leds_in_row: 7'd0, zigzag_mode: 1'b1,
                   glyph_width: 4'd12, glyph_height: 5'd8, first_font_char: 8'd32});
    send_render(render_req(0, 0, 0, 64));
    wait_idle();
    // wide glyph: columns past the byte render blank
    apply_config('{matrix_rows: 5'd8, leds_in_row: 7'd40, zigzag_mode: 1'b1,
                   glyph_width: 4'd12, glyph_height: 5'd8, first_font_char: 8'd32});
    send_render(render_req(1, 0, 7, 64));
    send_render(render_req(6, 3, 0, 12));
    wait_idle();
  endtask

  // serpentine layout, with undrawable rows in between that must not flip
  task automatic test_zigzag_rows();
    apply_config('{matrix_rows: 5'd6, leds_in_row: 7'd24, zigzag_mode: 1'b1,
                   glyph_width: 4'd6, glyph_height: 5'd7, first_font_char: 8'd32});
    for (int i = 0; i < 8; i++) begin
      send_render(render_req(i % 6, i, i % 6, 40));
      if (i % 3 == 0) send_render(render_req(6 + i % 3, 0, 0, 40));
    end
    wait_idle();
  endtask

  // long output stall while full rows keep coming: the command queue must fill up
  task automatic test_output_stall();
    led_req_t rows [8];
    apply_config('{matrix_rows: 5'd16, leds_in_row: 7'd64, zigzag_mode: 1'b0,
                   glyph_width: 4'd8, glyph_height: 5'd16, first_font_char: 8'd32});
    foreach (rows[i]) begin
      rows[i] = render_req($urandom_range(0, 15), $urandom_range(0, 20), $urandom_range(0, 7), 64);
      load_render_sources(rows[i]);
    end
    in_valid <= 1'b0;
    burst_left = 100;
    holds_asked++;
    foreach (rows[i]) send_item(rows[i]);
    wait_idle();
  endtask

  // spread what is left of the item budget over the random phases
  task automatic test_random_traffic();
    led_req_t r;
    int unsigned base, left, goal, pick;
    base = items_sent;
    left = ITEM_TARGET > base ? ITEM_TARGET - base : 0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      apply_config(phase == 0 ? '{matrix_rows: 5'd8, leds_in_row: 7'd32, zigzag_mode: 1'b0,
                                  glyph_width: 4'd8, glyph_height: 5'd8,
                                  first_font_char: 8'd32}
                              : rand_cfg());
      goal = base + left * (phase + 1) / RANDOM_PHASES;
      do begin
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          send_item(store_write(KIND_FONT_WR, $urandom_range(0, 1023), 8'($urandom_range(0, 255))));
        end else if (pick < 32) begin
          if ($urandom_range(0, 9) == 0) begin
            send_item(store_write(KIND_TEXT_WR, $urandom_range(64, 1023), rand_code()));
          end else begin
            send_item(store_write(KIND_TEXT_WR, $urandom_range(0, 63), rand_code()));
          end
        end else if (pick < 35) begin
          send_item(store_write(KIND_UNUSED, $urandom_range(0, 1023), 8'($urandom_range(0, 255))));
        end else begin
          r = rand_render();
          send_render(r);
        end
      end while (items_sent < goal);
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    shadow_cfg = '{matrix_rows: 5'd8, leds_in_row: 7'd32, zigzag_mode: 1'b0,
                   glyph_width: 4'd8, glyph_height: 5'd8, first_font_char: 8'd32};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_store_and_blank_cases();
    test_config_extremes();
    test_zigzag_rows();
    test_output_stall();
    test_random_traffic();

    wait_idle();
    if (pending_pixels.size() != 0)
      flag($sformatf("%0d pixels never arrived", pending_pixels.size()));
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
